// File: hw/rtl/spps_pkg.sv
`default_nettype none
package spps_pkg;

	typedef logic [7:0] angle_t;
	typedef logic [9:0] ticks_t;
	typedef logic [3:0] phase_t;
	typedef logic [2:0] pose_idx_t;
	typedef logic [2:0] cfg_idx_t;

	localparam int JOINTS_HW = 3;
	localparam int POSE_COUNT = 6;
	localparam logic [1:0] JOINT_COUNT = 2'd3;

	localparam phase_t PH_IDLE     = 4'd0;
	localparam phase_t PH_CONVEYOR = 4'd1;
	localparam phase_t PH_GRIP     = 4'd2;
	localparam phase_t PH_WAYPOINT = 4'd3;
	localparam phase_t PH_DWELL    = 4'd4;
	localparam phase_t PH_BIN      = 4'd5;
	localparam phase_t PH_PLACE    = 4'd6;
	localparam phase_t PH_RELEASE  = 4'd7;
	localparam phase_t PH_STANDBY  = 4'd8;
	localparam phase_t PH_DONE     = 4'd9;

	localparam pose_idx_t POSE_CONV1    = 3'd0;
	localparam pose_idx_t POSE_CONV2    = 3'd1;
	localparam pose_idx_t POSE_STANDBY  = 3'd2;
	localparam pose_idx_t POSE_RECYCLE  = 3'd3;
	localparam pose_idx_t POSE_DEFECT   = 3'd4;
	localparam pose_idx_t POSE_WAYPOINT = 3'd5;

	localparam cfg_idx_t CFG_STEP_SIZE      = 3'd0;
	localparam cfg_idx_t CFG_STEP_PERIOD    = 3'd1;
	localparam cfg_idx_t CFG_GRIP_DWELL     = 3'd2;
	localparam cfg_idx_t CFG_WAYPOINT_DWELL = 3'd3;
	localparam cfg_idx_t CFG_PLACE_DWELL    = 3'd4;
	localparam cfg_idx_t CFG_RELEASE_DWELL  = 3'd5;

	localparam angle_t POSE_TABLE [POSE_COUNT][JOINTS_HW] = '{
		'{8'd20,  8'd10, 8'd120},
		'{8'd20,  8'd50, 8'd180},
		'{8'd80,  8'd40, 8'd0},
		'{8'd127, 8'd35, 8'd170},
		'{8'd160, 8'd35, 8'd170},
		'{8'd100, 8'd50, 8'd80}
	};

	typedef struct packed {
		logic   step;
		angle_t next_angle;
	} step_res_t;

	typedef struct packed {
		phase_t    phase;
		ticks_t    wait_ticks;
		logic      mag_write;
		logic      mag_value;
		logic      load_pose;
		pose_idx_t pose;
		logic      done;
	} enter_t;

endpackage
`default_nettype wire

// File: hw/rtl/spps_step_unit.sv
`default_nettype none
module spps_step_unit (
	input  wire spps_pkg::angle_t   cur,
	input  wire spps_pkg::angle_t   tgt,
	input  wire spps_pkg::angle_t   step_size,
	output spps_pkg::step_res_t     res
);

	logic [8:0]       diff;
	logic             up;
	spps_pkg::angle_t gap;
	spps_pkg::angle_t s_eff;

	always_comb begin
		s_eff = (step_size == '0) ? 8'd1 : step_size;
		diff = {1'b0, tgt} - {1'b0, cur};
		up = ~diff[8];
		gap = up ? diff[7:0] : 8'(-diff);
		res.step = gap > s_eff;
		res.next_angle = up ? 8'(cur + s_eff) : 8'(cur - s_eff);
	end

endmodule
`default_nettype wire

// File: hw/rtl/servo_pick_place_sequencer.sv
// Each transaction is processed by a small sequencer that takes one step per cycle.
// Its steps are joint snaps, joint ramp steps, dwell decrements and phase changes;
// joint snaps and ramp steps all use one shared angle step unit.
// One transaction is in flight at a time; the next is taken once the result leaves.
// Reset is asynchronous and active low; joints and targets return to standby.
`default_nettype none
module servo_pick_place_sequencer (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        kind,
	input  wire        sequence_type,
	input  wire  [1:0] conveyor_position,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] base_angle,
	output logic [7:0] shoulder_angle,
	output logic [7:0] elbow_angle,
	output logic       magnet_on,
	output logic       busy_res,
	output logic [3:0] phase,
	output logic       sequence_done,
	input  wire        cfg_we,
	input  wire  [2:0] cfg_index,
	input  wire  [9:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	logic                tick_q;
	logic                done_q;
	logic                bin_q;
	logic                mag_q;
	spps_pkg::phase_t    phase_q;
	logic [1:0]          active_q;
	spps_pkg::ticks_t    wait_q;
	spps_pkg::angle_t    joint_q  [spps_pkg::JOINTS_HW];
	spps_pkg::angle_t    target_q [spps_pkg::JOINTS_HW];
	spps_pkg::angle_t    step_size_q;
	spps_pkg::ticks_t    step_period_q;
	spps_pkg::ticks_t    grip_dwell_q;
	spps_pkg::ticks_t    waypoint_dwell_q;
	spps_pkg::ticks_t    place_dwell_q;
	spps_pkg::ticks_t    release_dwell_q;

	logic                in_accept;
	logic                conv_ok;
	logic                is_dwell;
	logic                is_move;
	logic                rev;
	logic [1:0]          j_raw;
	logic [1:0]          jidx;
	logic                do_enter;
	spps_pkg::phase_t    ent_code;
	spps_pkg::enter_t    ent;
	spps_pkg::ticks_t    period_eff;
	spps_pkg::step_res_t step_res;

	assign in_accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign conv_ok = (conveyor_position == 2'd1) || (conveyor_position == 2'd2);
	assign period_eff = (step_period_q == '0) ? 10'd1 : step_period_q;

	always_comb begin
		is_dwell = (phase_q == spps_pkg::PH_GRIP) || (phase_q == spps_pkg::PH_DWELL) ||
			(phase_q == spps_pkg::PH_PLACE) || (phase_q == spps_pkg::PH_RELEASE);
		is_move = (phase_q == spps_pkg::PH_CONVEYOR) || (phase_q == spps_pkg::PH_WAYPOINT) ||
			(phase_q == spps_pkg::PH_BIN) || (phase_q == spps_pkg::PH_STANDBY);
		rev = (phase_q == spps_pkg::PH_WAYPOINT) || (phase_q == spps_pkg::PH_STANDBY);
		j_raw = rev ? 2'(spps_pkg::JOINT_COUNT - 2'd1 - active_q) : active_q;
		jidx = (j_raw > 2'd2) ? 2'd2 : j_raw;
	end

	spps_step_unit u_step (
		.cur       (joint_q[jidx]),
		.tgt       (target_q[jidx]),
		.step_size (step_size_q),
		.res       (step_res)
	);

	always_comb begin
		do_enter = 1'b0;
		if (state_q == S_IDLE) begin
			do_enter = in_accept && kind && (phase_q == spps_pkg::PH_IDLE);
		end else if (phase_q != spps_pkg::PH_IDLE && wait_q == '0) begin
			do_enter = is_dwell || (is_move && active_q >= spps_pkg::JOINT_COUNT);
		end
		if (state_q == S_IDLE) begin
			ent_code = conv_ok ? spps_pkg::PH_CONVEYOR : spps_pkg::PH_GRIP;
		end else begin
			ent_code = phase_q + 4'd1;
		end
	end

	always_comb begin
		ent.phase = ent_code;
		ent.wait_ticks = '0;
		ent.mag_write = 1'b0;
		ent.mag_value = 1'b0;
		ent.load_pose = 1'b0;
		ent.pose = spps_pkg::POSE_STANDBY;
		ent.done = 1'b0;
		case (ent_code)
			spps_pkg::PH_CONVEYOR: begin
				ent.load_pose = 1'b1;
				ent.pose = (conveyor_position == 2'd1) ? spps_pkg::POSE_CONV1
					: spps_pkg::POSE_CONV2;
			end
			spps_pkg::PH_GRIP: begin
				ent.mag_write = 1'b1;
				ent.mag_value = 1'b1;
				ent.wait_ticks = grip_dwell_q;
			end
			spps_pkg::PH_WAYPOINT: begin
				ent.load_pose = 1'b1;
				ent.pose = spps_pkg::POSE_WAYPOINT;
			end
			spps_pkg::PH_DWELL: ent.wait_ticks = waypoint_dwell_q;
			spps_pkg::PH_BIN: begin
				ent.load_pose = 1'b1;
				ent.pose = bin_q ? spps_pkg::POSE_RECYCLE : spps_pkg::POSE_DEFECT;
			end
			spps_pkg::PH_PLACE: ent.wait_ticks = place_dwell_q;
			spps_pkg::PH_RELEASE: begin
				ent.mag_write = 1'b1;
				ent.mag_value = 1'b0;
				ent.wait_ticks = release_dwell_q;
			end
			spps_pkg::PH_STANDBY: begin
				ent.load_pose = 1'b1;
				ent.pose = spps_pkg::POSE_STANDBY;
			end
			spps_pkg::PH_DONE: begin
				ent.phase = spps_pkg::PH_IDLE;
				ent.done = 1'b1;
			end
			default: ent.phase = spps_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			tick_q <= 1'b0;
			done_q <= 1'b0;
			bin_q <= 1'b0;
			mag_q <= 1'b0;
			phase_q <= spps_pkg::PH_IDLE;
			active_q <= '0;
			wait_q <= '0;
			for (int i = 0; i < spps_pkg::JOINTS_HW; i++) begin
				joint_q[i] <= spps_pkg::POSE_TABLE[spps_pkg::POSE_STANDBY][i];
				target_q[i] <= spps_pkg::POSE_TABLE[spps_pkg::POSE_STANDBY][i];
			end
			step_size_q <= 8'd2;
			step_period_q <= 10'd15;
			grip_dwell_q <= 10'd300;
			waypoint_dwell_q <= 10'd150;
			place_dwell_q <= 10'd250;
			release_dwell_q <= 10'd250;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					spps_pkg::CFG_STEP_SIZE:      step_size_q <= cfg_data[7:0];
					spps_pkg::CFG_STEP_PERIOD:    step_period_q <= cfg_data;
					spps_pkg::CFG_GRIP_DWELL:     grip_dwell_q <= cfg_data;
					spps_pkg::CFG_WAYPOINT_DWELL: waypoint_dwell_q <= cfg_data;
					spps_pkg::CFG_PLACE_DWELL:    place_dwell_q <= cfg_data;
					spps_pkg::CFG_RELEASE_DWELL:  release_dwell_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_RUN;
						tick_q <= ~kind;
						done_q <= 1'b0;
						if (kind && phase_q == spps_pkg::PH_IDLE) begin
							bin_q <= sequence_type;
						end
					end
				end
				S_RUN: begin
					if (phase_q == spps_pkg::PH_IDLE) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
					end else if (wait_q != '0) begin
						if (!tick_q) begin
							state_q <= S_IDLE;
							out_valid_q <= 1'b1;
						end else begin
							tick_q <= 1'b0;
							wait_q <= wait_q - 10'd1;
							if (wait_q != 10'd1) begin
								state_q <= S_IDLE;
								out_valid_q <= 1'b1;
							end
						end
					end else if (is_move && active_q < spps_pkg::JOINT_COUNT) begin
						if (step_res.step) begin
							joint_q[jidx] <= step_res.next_angle;
							wait_q <= period_eff;
							state_q <= S_IDLE;
							out_valid_q <= 1'b1;
						end else begin
							joint_q[jidx] <= target_q[jidx];
							active_q <= active_q + 2'd1;
						end
					end else if (!is_move && !is_dwell) begin
						phase_q <= spps_pkg::PH_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (do_enter) begin
				phase_q <= ent.phase;
				active_q <= '0;
				wait_q <= ent.wait_ticks;
				if (ent.mag_write) begin
					mag_q <= ent.mag_value;
				end
				if (ent.load_pose) begin
					for (int i = 0; i < spps_pkg::JOINTS_HW; i++) begin
						target_q[i] <= spps_pkg::POSE_TABLE[ent.pose][i];
					end
				end
				if (ent.done) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign base_angle = joint_q[0];
	assign shoulder_angle = joint_q[1];
	assign elbow_angle = joint_q[2];
	assign magnet_on = mag_q;
	assign busy_res = (phase_q != spps_pkg::PH_IDLE);
	assign phase = phase_q;
	assign sequence_done = done_q;

endmodule
`default_nettype wire

// File: hw/rtl/spps_checker.sv
`default_nettype none
module spps_checker (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	input  wire       in_stall,
	input  wire       out_valid,
	input  wire       out_stall,
	input  wire [7:0] base_angle,
	input  wire       magnet_on,
	input  wire       busy_res,
	input  wire [3:0] phase,
	input  wire       sequence_done
);

	// A stalled result stays valid and keeps its base angle.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(base_angle))
		else $error("result changed while stalled");

	// No result is shown in the cycle after a transaction is accepted.
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result shown in the cycle after acceptance");

	// The busy flag follows the phase.
	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy_res == (phase != spps_pkg::PH_IDLE))
		else $error("busy flag disagrees with phase");

	// The magnet is energized only inside a cycle.
	a_magnet_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && magnet_on |-> busy_res)
		else $error("magnet on while idle");

	// A completed cycle leaves the arm idle with the magnet off.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_done |-> !busy_res && !magnet_on)
		else $error("cycle end reported while busy");

endmodule

bind servo_pick_place_sequencer spps_checker u_spps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.base_angle    (base_angle),
	.magnet_on     (magnet_on),
	.busy_res      (busy_res),
	.phase         (phase),
	.sequence_done (sequence_done)
);
`default_nettype wire
